@@ rtl/core/tccw_pkg.sv @@
// Shared types and constants for the text console character writer.
// Holds controller states, controller/datapath command and status bundles.
// No dependencies.
`timescale 1ns / 1ps

package tccw_pkg;

  // Character codes with special meaning
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;

  // Input item kinds (carried on tuser)
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Configuration register indexes and reset values
  localparam logic       REG_TEXT_ATTR   = 1'b0;
  localparam logic       REG_FILL_ATTR   = 1'b1;
  localparam logic [7:0] TEXT_ATTR_RESET = 8'h1f;
  localparam logic [7:0] FILL_ATTR_RESET = 8'h07;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_SCROLL,
    ST_PUT_CHAR,
    ST_FILL,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic clr_write;
    logic scroll_step;
    logic write_char;
    logic fill_step;
    logic rd_issue;
    logic rd_capture;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_read;
    logic in_newline;
    logic cursor_full;
    logic clr_last;
    logic scroll_last;
    logic col_zero;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/tccw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the screen cell store.
`timescale 1ns / 1ps

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/tccw_ctrl.sv @@
// Controller state machine for the text console character writer.
// Depends on tccw_pkg; drives tccw_dpath through cmd_t, reads status_t.
`timescale 1ns / 1ps

module tccw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tccw_pkg::status_t st,
  output tccw_pkg::cmd_t    cmd
);
  import tccw_pkg::*;

  state_t state, state_next;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (st.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          priority if (st.in_read)     state_next = ST_RD_ADDR;
          else if (st.in_newline)      state_next = ST_FILL;
          else if (st.cursor_full)     state_next = ST_SCROLL;
          else                         state_next = ST_PUT_CHAR;
        end
      end
      ST_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd.rd_capture = 1'b1;
        state_next     = ST_DONE;
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (st.scroll_last) state_next = ST_PUT_CHAR;
      end
      ST_PUT_CHAR: begin
        cmd.write_char = 1'b1;
        state_next     = ST_DONE;
      end
      ST_FILL: begin
        // pad until the cursor reaches a row start
        if (!st.col_zero) begin
          cmd.fill_step = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/core/tccw_dpath.sv @@
// Datapath for the text console character writer: cursor, column, sweep
// counter, cell store and result register. Depends on tccw_pkg and tccw_ram.
`timescale 1ns / 1ps

module tccw_dpath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tccw_pkg::cmd_t                        cmd,
  output tccw_pkg::status_t                     st,
  input  logic                                  in_mode,
  input  logic [7:0]                            in_char,
  input  logic [$clog2(COLUMNS*ROWS+1)-1:0]     in_cell,
  input  logic [7:0]                            text_attr,
  input  logic [7:0]                            fill_attr,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            out_char,
  output logic [7:0]                            out_attr,
  output logic [$clog2(COLUMNS*ROWS+1)-1:0]     out_cursor
);
  import tccw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int SC_LEN = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [CW-1:0]    CELLS_C    = CW'(CELLS);
  localparam logic [CW-1:0]    LAST_CELL  = CW'(CELLS - 1);
  localparam logic [CW-1:0]    SC_LEN_C   = CW'(SC_LEN);
  localparam logic [CW-1:0]    COLUMNS_C  = CW'(COLUMNS);
  localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);

  logic [7:0]       code_q;
  logic [CW-1:0]    cell_q;
  logic [CW-1:0]    cursor;
  logic [COL_W-1:0] col;
  logic [CW-1:0]    cnt;
  logic [7:0]       res_char;
  logic [7:0]       res_attr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_src;
  logic          advance;

  assign cnt_m1  = cnt - CW'(1);
  assign cnt_src = cnt + COLUMNS_C;
  assign advance = cmd.write_char | cmd.fill_step;

  // Status toward the controller
  assign st.in_read     = (in_mode == MODE_READ);
  assign st.in_newline  = (in_char == NEWLINE_CODE);
  assign st.cursor_full = (cursor == CELLS_C);
  assign st.clr_last    = (cnt == LAST_CELL);
  assign st.scroll_last = (cnt == SC_LEN_C);
  assign st.col_zero    = (col == '0);
  assign st.out_free    = !out_valid || out_ready;

  // Latched item fields
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      code_q <= in_char;
      cell_q <= in_cell;
    end
  end

  // Sweep counter for the clearing pass and the scroll copy
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr_write) begin
      cnt <= st.clr_last ? '0 : cnt + CW'(1);
    end else if (cmd.scroll_step) begin
      cnt <= st.scroll_last ? '0 : cnt + CW'(1);
    end
  end

  // Cursor and its column
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      col    <= '0;
    end else if (cmd.scroll_step && st.scroll_last) begin
      cursor <= cursor - COLUMNS_C;
    end else if (advance) begin
      cursor <= cursor + CW'(1);
      col    <= (col == LAST_COL) ? '0 : col + COL_W'(1);
    end
  end

  // Cell store write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    priority if (cmd.clr_write) begin
      ram_we    = 1'b1;
      ram_waddr = cnt[AW-1:0];
    end else if (cmd.scroll_step) begin
      // copy writes back the cell read in the previous cycle
      ram_we    = (cnt != '0);
      ram_waddr = cnt_m1[AW-1:0];
      ram_wdata = ram_rdata;
    end else if (cmd.write_char) begin
      ram_we    = 1'b1;
      ram_waddr = cursor[AW-1:0];
      ram_wdata = {text_attr, code_q};
    end else if (cmd.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = cursor[AW-1:0];
      ram_wdata = {fill_attr, SPACE_CODE};
    end else begin
      ram_we = 1'b0;
    end
  end

  // Cell store read port: one row below during scroll, else the read item
  always_comb begin
    if (cmd.scroll_step) begin
      ram_re    = !st.scroll_last;
      ram_raddr = cnt_src[AW-1:0];
    end else begin
      ram_re    = cmd.rd_issue;
      ram_raddr = cell_q[AW-1:0];
    end
  end

  tccw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Cell result: zero unless a read hits a cell on screen
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      res_char <= '0;
      res_attr <= '0;
    end else if (cmd.rd_capture && (cell_q < CELLS_C)) begin
      res_char <= ram_rdata[7:0];
      res_attr <= ram_rdata[15:8];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char   <= res_char;
      out_attr   <= res_attr;
      out_cursor <= cursor;
    end
  end

endmodule

@@ rtl/core/text_console_char_writer_unit.sv @@
// Top level of the text console character writer: stream ports, APB
// register file, controller and datapath. Depends on tccw_pkg, tccw_ctrl,
// tccw_dpath.
`timescale 1ns / 1ps

// Text console of COLUMNS x ROWS cells (character byte plus attribute byte)
// with one cursor. After reset the block zeroes every cell of the cell
// store and takes no item meanwhile; register writes are taken at any
// time. A printable put writes its character at the cursor; when the
// screen is full it first scrolls, moving each cell below the top row up
// one row, one at a time, through the one read port and the one write
// port of the cell RAM. A newline pads with fill cells until the cursor
// reaches a row start; a read issues the RAM read and then captures the
// registered read data. One item is worked on at a time; the next is
// accepted while the previous result waits in the output register.
// tuser on the input carries the mode (0 put, 1 read).
module text_console_char_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                        clk,
  input  logic                                        rst,
  // input stream
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // [7:0] char_code, [CW+7:8] read_cell, zero padded
  input  logic [((8+$clog2(COLUMNS*ROWS+1)+7)/8)*8-1:0]  s_tdata,
  // [0] mode
  input  logic                                        s_tuser,
  // result stream
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // [7:0] cell_char, [15:8] cell_attr, [CW+15:16] cursor, zero padded
  output logic [((16+$clog2(COLUMNS*ROWS+1)+7)/8)*8-1:0] m_tdata,
  // configuration
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [2:0]                                  paddr,
  input  logic [31:0]                                 pwdata,
  output logic [31:0]                                 prdata,
  output logic                                        pready
);
  import tccw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int OUT_W = ((16 + CW + 7) / 8) * 8;
  localparam logic [CW-1:0] CELLS_C = CW'(CELLS);

  logic [7:0] text_attr;
  logic [7:0] fill_attr;
  logic       reg_sel;
  logic       cfg_write;

  cmd_t    cmd;
  status_t st;

  logic [7:0]    out_char;
  logic [7:0]    out_attr;
  logic [CW-1:0] out_cursor;

  // Register file
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= TEXT_ATTR_RESET;
      fill_attr <= FILL_ATTR_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_TEXT_ATTR: text_attr <= pwdata[7:0];
        REG_FILL_ATTR: fill_attr <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TEXT_ATTR: prdata = {24'd0, text_attr};
      REG_FILL_ATTR: prdata = {24'd0, fill_attr};
      default:       prdata = '0;
    endcase
  end

  tccw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .st      (st),
    .cmd     (cmd)
  );

  tccw_dpath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_mode   (s_tuser),
    .in_char   (s_tdata[7:0]),
    .in_cell   (s_tdata[8 +: CW]),
    .text_attr (text_attr),
    .fill_attr (fill_attr),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .out_attr  (out_attr),
    .out_cursor(out_cursor)
  );

  assign m_tdata = OUT_W'({out_cursor, out_attr, out_char});

  // Checks

  // cursor reported never runs past the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_cursor <= CELLS_C))
    else $error("cursor beyond screen end");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in progress");

  // a result is loaded only from the done state with a free output slot
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over a pending result");

endmodule
